FILE: hdl/iso14443a_card_select_sequencer_macros.svh
// assertion macros for the card select sequencer
`ifndef ISO14443A_CARD_SELECT_SEQUENCER_MACROS_SVH
`define ISO14443A_CARD_SELECT_SEQUENCER_MACROS_SVH

// property checked on every clock edge outside reset
`define ISOSEL_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in this cycle, consequent in the next
`define ISOSEL_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/isosel_pkg.sv
// shared types and protocol constants of the card select sequencer
package isosel_pkg;

	localparam int RESPONSE_BYTES_DEF = 5;

	localparam int UID_W = 56;

	// input operations
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_END   = 2'd2,
		OP_NOANS = 2'd3
	} op_t;

	// report status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_ANSWER = 2'd1;
	localparam logic [1:0] ST_BAD_FRAME = 2'd2;

	// result kinds
	localparam logic KIND_FRAME  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// frame bytes
	localparam logic [7:0] REQA_CMD     = 8'h26;
	localparam logic [7:0] SEL_CL1      = 8'h93;
	localparam logic [7:0] SEL_CL2      = 8'h95;
	localparam logic [7:0] NVB_SELECT   = 8'h70;
	localparam logic [7:0] NVB_ANTICOLL = 8'h20;
	localparam logic [7:0] HLTA_CMD     = 8'h50;
	localparam logic [7:0] HLTA_ARG     = 8'h00;
	localparam logic [2:0] REQA_BITS    = 3'd7;
	localparam int         SAK_CASCADE_BIT = 2;

	// sequences of results that one input can start
	typedef enum logic [2:0] {
		RUN_NONE,
		RUN_REQA,
		RUN_ANTICOLL,
		RUN_SELECT,
		RUN_DONE,
		RUN_FAIL
	} run_t;

	// payload holds frame bytes, first byte on top, or the uid of a report
	typedef struct packed {
		run_t             kind;
		logic [UID_W-1:0] payload;
		logic [2:0]       uid_len;
		logic [7:0]       sak;
		logic [1:0]       status;
	} run_desc_t;

endpackage

FILE: hdl/isosel_in_if.sv
// channel carrying card events into the sequencer
interface isosel_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] rx_data;

	modport source (output valid, output op, output rx_data, input ready);
	modport sink (input valid, input op, input rx_data, output ready);
endinterface

FILE: hdl/isosel_out_if.sv
// channel carrying frame bytes and reports out of the sequencer
interface isosel_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  tx_data;
	logic [2:0]  tx_tail_bits;
	logic        append_crc;
	logic        last;
	logic [1:0]  status;
	logic [55:0] uid;
	logic [2:0]  uid_len;
	logic [7:0]  sak;

	modport source (output valid, output kind, output tx_data, output tx_tail_bits,
		output append_crc, output last, output status, output uid, output uid_len,
		output sak, input ready);
	modport sink (input valid, input kind, input tx_data, input tx_tail_bits,
		input append_crc, input last, input status, input uid, input uid_len,
		input sak, output ready);
endinterface

FILE: hdl/isosel_ctrl.sv
// selection state machine: collects card replies and decides the next frame
module isosel_ctrl import isosel_pkg::*; #(
	parameter int RESPONSE_BYTES = RESPONSE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	isosel_in_if.sink   cmd,
	input  logic        room,
	output run_desc_t   desc
);

	localparam int IDX_W = $clog2(RESPONSE_BYTES);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ATQA,
		PH_UID,
		PH_SAK
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [2:0]       rx_count_q, rx_count_d;
	logic [UID_W-1:0] uid_q, uid_d;
	logic             casc_q, casc_d;
	logic [7:0]       sak_q, sak_d;
	logic [7:0]       rxbuf_q [RESPONSE_BYTES];
	logic             acc;
	logic             buf_we;
	logic [7:0]       bcc;
	logic [31:0]      part;

	assign cmd.ready = room;
	assign acc = cmd.valid && room;

	assign bcc = rxbuf_q[0] ^ rxbuf_q[1] ^ rxbuf_q[2] ^ rxbuf_q[3];
	assign part = {rxbuf_q[0], rxbuf_q[1], rxbuf_q[2], rxbuf_q[3]};

	// bytes past the buffer are dropped, the count saturates at seven
	assign buf_we = acc && op_t'(cmd.op) == OP_BYTE && phase_q != PH_IDLE
		&& 32'(rx_count_q) < RESPONSE_BYTES && rx_count_q != 3'd7;

	always_comb begin
		phase_d    = phase_q;
		rx_count_d = rx_count_q;
		uid_d      = uid_q;
		casc_d     = casc_q;
		sak_d      = sak_q;
		desc       = '{kind: RUN_NONE, payload: '0, uid_len: '0, sak: '0, status: ST_OK};
		if (acc) begin
			if (op_t'(cmd.op) == OP_START) begin
				rx_count_d = '0;
				uid_d      = '0;
				casc_d     = 1'b0;
				sak_d      = '0;
				phase_d    = PH_ATQA;
				desc.kind  = RUN_REQA;
			end else if (phase_q != PH_IDLE) begin
				unique case (op_t'(cmd.op))
					OP_START: begin
					end
					OP_BYTE: begin
						if (rx_count_q != 3'd7) begin
							rx_count_d = rx_count_q + 3'd1;
						end
					end
					OP_NOANS: begin
						rx_count_d  = '0;
						phase_d     = PH_IDLE;
						desc.kind   = RUN_FAIL;
						desc.status = ST_NO_ANSWER;
					end
					OP_END: begin
						rx_count_d  = '0;
						desc.kind   = RUN_FAIL;
						desc.status = ST_BAD_FRAME;
						phase_d     = PH_IDLE;
						unique case (phase_q)
							PH_ATQA: begin
								if (rx_count_q >= 3'd2) begin
									desc.kind    = RUN_ANTICOLL;
									desc.payload = {SEL_CL1, NVB_ANTICOLL, 40'h0};
									phase_d      = PH_UID;
								end
							end
							PH_UID: begin
								if (rx_count_q >= 3'd5 && bcc == rxbuf_q[4]) begin
									// at level two the cascade tag byte falls off the top
									uid_d = casc_q ? {uid_q[23:0], part}
										: {24'h0, part};
									desc.kind    = RUN_SELECT;
									desc.payload = {casc_q ? SEL_CL2 : SEL_CL1, NVB_SELECT,
										rxbuf_q[0], rxbuf_q[1], rxbuf_q[2], rxbuf_q[3],
										rxbuf_q[4]};
									phase_d      = PH_SAK;
								end
							end
							PH_SAK: begin
								if (rx_count_q != 3'd0) begin
									sak_d = rxbuf_q[0];
									if (rxbuf_q[0][SAK_CASCADE_BIT] && !casc_q) begin
										casc_d       = 1'b1;
										desc.kind    = RUN_ANTICOLL;
										desc.payload = {SEL_CL2, NVB_ANTICOLL, 40'h0};
										phase_d      = PH_UID;
									end else begin
										desc.kind    = RUN_DONE;
										desc.payload = uid_q;
										desc.uid_len = casc_q ? 3'd7 : 3'd4;
										desc.sak     = rxbuf_q[0];
										desc.status  = ST_OK;
									end
								end
							end
							default: begin
							end
						endcase
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			rx_count_q <= '0;
			uid_q      <= '0;
			casc_q     <= 1'b0;
			sak_q      <= '0;
		end else begin
			phase_q    <= phase_d;
			rx_count_q <= rx_count_d;
			uid_q      <= uid_d;
			casc_q     <= casc_d;
			sak_q      <= sak_d;
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			rxbuf_q[rx_count_q[IDX_W-1:0]] <= cmd.rx_data;
		end
	end

endmodule

FILE: hdl/isosel_emit.sv
// result register: holds one run and hands out its words one per cycle while the receiver is ready
module isosel_emit import isosel_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  run_desc_t    desc,
	output logic         room,
	isosel_out_if.source res
);

	logic             busy_q;
	run_desc_t        run_q;
	logic [2:0]       idx_q;
	logic [2:0]       final_idx;
	logic             at_last;
	logic             done;
	logic [UID_W-1:0] shifted;

	always_comb begin
		unique case (run_q.kind)
			RUN_ANTICOLL: final_idx = 3'd1;
			RUN_SELECT:   final_idx = 3'd6;
			RUN_DONE:     final_idx = 3'd2;
			default:      final_idx = 3'd0;
		endcase
	end

	assign at_last = idx_q == final_idx;
	assign done    = res.valid && res.ready && at_last;
	// next input may enter as the last word of this run leaves
	assign room    = !busy_q || (res.ready && at_last);

	assign shifted = run_q.payload << {idx_q, 3'b000};

	always_comb begin
		res.valid        = busy_q;
		res.last         = at_last;
		res.kind         = KIND_FRAME;
		res.tx_data      = '0;
		res.tx_tail_bits = '0;
		res.append_crc   = 1'b0;
		res.status       = ST_OK;
		res.uid          = '0;
		res.uid_len      = '0;
		res.sak          = '0;
		unique case (run_q.kind)
			RUN_REQA: begin
				res.tx_data      = REQA_CMD;
				res.tx_tail_bits = REQA_BITS;
			end
			RUN_ANTICOLL: begin
				res.tx_data = shifted[UID_W-1 -: 8];
			end
			RUN_SELECT: begin
				res.tx_data    = shifted[UID_W-1 -: 8];
				res.append_crc = 1'b1;
			end
			RUN_DONE: begin
				if (at_last) begin
					res.kind    = KIND_REPORT;
					res.uid     = run_q.payload;
					res.uid_len = run_q.uid_len;
					res.sak     = run_q.sak;
				end else begin
					res.tx_data    = (idx_q == 3'd0) ? HLTA_CMD : HLTA_ARG;
					res.append_crc = 1'b1;
				end
			end
			RUN_FAIL: begin
				res.kind   = KIND_REPORT;
				res.status = run_q.status;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (desc.kind != RUN_NONE) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (res.valid && res.ready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (desc.kind != RUN_NONE) begin
			run_q <= desc;
		end
	end

endmodule

FILE: hdl/iso14443a_card_select_sequencer.sv
// top level of the reader-side card select sequencer
// Drives ISO 14443-A selection: a start word emits REQA, then card bytes are
// collected one per word and each end-of-frame word checks the reply (ATQA,
// UID+BCC, SAK) and answers with anticollision, SELECT (append_crc set) or,
// after the last cascade level, HALT plus a report; a failed check or a
// no-answer word gives a failure report. Input words are taken while the
// result register has room, and results leave from it at one word per cycle
// while the receiver is ready; a SELECT frame is the longest run, at seven words.
// A new input is taken in the same cycle the last result of the previous one
// is accepted downstream.
`include "iso14443a_card_select_sequencer_macros.svh"

module iso14443a_card_select_sequencer import isosel_pkg::*; #(
	parameter int RESPONSE_BYTES = RESPONSE_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	isosel_in_if.sink    cmd,
	isosel_out_if.source res
);

	run_desc_t desc;
	logic      room;

	isosel_ctrl #(
		.RESPONSE_BYTES(RESPONSE_BYTES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.room   (room),
		.desc   (desc)
	);

	isosel_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.desc   (desc),
		.room   (room),
		.res    (res)
	);

	`ISOSEL_ASSERT_NEXT(a_start_reqa, cmd.valid && cmd.ready && cmd.op == OP_START, res.valid && res.tx_data == REQA_CMD && res.tx_tail_bits == REQA_BITS && res.last, "start did not lead to reqa")
	`ISOSEL_ASSERT(a_report_last, res.valid && res.kind == KIND_REPORT |-> res.last, "report not last word")
	`ISOSEL_ASSERT(a_no_overrun, cmd.ready && res.valid |-> res.ready && res.last, "input taken over pending run")

endmodule

FILE: dv/iso14443a_card_select_sequencer_checker.sv
`timescale 1ns / 1ps
// checker that predicts the words of the card select sequencer and compares its output
module iso14443a_card_select_sequencer_checker import isosel_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	isosel_in_if        cmd,
	isosel_out_if       res,
	output int unsigned fails,
	output int unsigned waiting
);

	localparam logic [2:0] COUNT_MAX      = 3'd7;
	localparam logic [2:0] UID_LEN_SINGLE = 3'd4;
	localparam logic [2:0] UID_LEN_DOUBLE = 3'd7;
	localparam int         SHOWN_MAX      = 10;

	typedef enum logic [1:0] {
		WAIT_IDLE,
		WAIT_ATQA,
		WAIT_UID,
		WAIT_SAK
	} sel_phase_t;

	typedef struct packed {
		logic             kind;
		logic [7:0]       tx_data;
		logic [2:0]       tx_tail_bits;
		logic             append_crc;
		logic             last;
		logic [1:0]       status;
		logic [UID_W-1:0] uid;
		logic [2:0]       uid_len;
		logic [7:0]       sak;
	} tx_word_t;

	sel_phase_t       ph;
	logic [2:0]       rx_count;
	logic [7:0]       rx_buf [RESPONSE_BYTES_DEF];
	logic [UID_W-1:0] uid_acc;
	logic             level_two;
	logic [7:0]       sak_acc;
	tx_word_t         burst[$];
	tx_word_t         awaited_words[$];
	tx_word_t         got;
	tx_word_t         want;

	function automatic void push_frame(input logic [7:0] data, input logic [2:0] bits,
		input logic crc);
		burst.push_back('{KIND_FRAME, data, bits, crc, 1'b0, ST_OK, '0, 3'd0, 8'd0});
	endfunction

	function automatic void push_report(input logic [1:0] status, input logic [UID_W-1:0] uid,
		input logic [2:0] len, input logic [7:0] sak);
		burst.push_back('{KIND_REPORT, 8'd0, 3'd0, 1'b0, 1'b0, status, uid, len, sak});
	endfunction

	// one accepted input word: update the reader state, queue the words it causes
	task reader_step(input op_t op, input logic [7:0] data);
		logic [2:0]  n;
		logic [7:0]  bcc;
		logic [31:0] part;
		tx_word_t    w;
		burst.delete();
		if (op == OP_START) begin
			rx_count  = 3'd0;
			uid_acc   = '0;
			level_two = 1'b0;
			sak_acc   = 8'd0;
			push_frame(REQA_CMD, REQA_BITS, 1'b0);
			ph = WAIT_ATQA;
		end else if (ph == WAIT_IDLE) begin
			// nothing to do outside a run
		end else if (op == OP_BYTE) begin
			if (rx_count < RESPONSE_BYTES_DEF)
				rx_buf[rx_count] = data;
			if (rx_count < COUNT_MAX)
				rx_count = rx_count + 3'd1;
		end else if (op == OP_NOANS) begin
			rx_count = 3'd0;
			push_report(ST_NO_ANSWER, '0, 3'd0, 8'd0);
			ph = WAIT_IDLE;
		end else begin
			n = rx_count;
			rx_count = 3'd0;
			case (ph)
				WAIT_ATQA: begin
					if (n < 3'd2) begin
						push_report(ST_BAD_FRAME, '0, 3'd0, 8'd0);
						ph = WAIT_IDLE;
					end else begin
						push_frame(SEL_CL1, 3'd0, 1'b0);
						push_frame(NVB_ANTICOLL, 3'd0, 1'b0);
						ph = WAIT_UID;
					end
				end
				WAIT_UID: begin
					bcc = rx_buf[0] ^ rx_buf[1] ^ rx_buf[2] ^ rx_buf[3];
					if (n < 3'd5 || bcc != rx_buf[4]) begin
						push_report(ST_BAD_FRAME, '0, 3'd0, 8'd0);
						ph = WAIT_IDLE;
					end else begin
						part = {rx_buf[0], rx_buf[1], rx_buf[2], rx_buf[3]};
						// level two keeps the three bytes after the cascade tag
						if (level_two)
							uid_acc = {uid_acc[23:0], part};
						else
							uid_acc = {24'd0, part};
						push_frame(level_two ? SEL_CL2 : SEL_CL1, 3'd0, 1'b1);
						push_frame(NVB_SELECT, 3'd0, 1'b1);
						for (int i = 0; i < 5; i++)
							push_frame(rx_buf[i], 3'd0, 1'b1);
						ph = WAIT_SAK;
					end
				end
				default: begin
					if (n < 3'd1) begin
						push_report(ST_BAD_FRAME, '0, 3'd0, 8'd0);
						ph = WAIT_IDLE;
					end else begin
						sak_acc = rx_buf[0];
						if (sak_acc[SAK_CASCADE_BIT] && !level_two) begin
							level_two = 1'b1;
							push_frame(SEL_CL2, 3'd0, 1'b0);
							push_frame(NVB_ANTICOLL, 3'd0, 1'b0);
							ph = WAIT_UID;
						end else begin
							push_frame(HLTA_CMD, 3'd0, 1'b1);
							push_frame(HLTA_ARG, 3'd0, 1'b1);
							push_report(ST_OK, uid_acc,
								level_two ? UID_LEN_DOUBLE : UID_LEN_SINGLE, sak_acc);
							ph = WAIT_IDLE;
						end
					end
				end
			endcase
		end
		if (burst.size() > 0) begin
			w = burst[burst.size() - 1];
			w.last = 1'b1;
			burst[burst.size() - 1] = w;
		end
		foreach (burst[i])
			awaited_words.push_back(burst[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph        = WAIT_IDLE;
			rx_count  = 3'd0;
			uid_acc   = '0;
			level_two = 1'b0;
			sak_acc   = 8'd0;
			fails     = 0;
			awaited_words.delete();
			waiting <= 0;
		end else begin
			if (cmd.valid && cmd.ready)
				reader_step(op_t'(cmd.op), cmd.rx_data);
			if (res.valid && res.ready) begin
				got = {res.kind, res.tx_data, res.tx_tail_bits, res.append_crc, res.last,
					res.status, res.uid, res.uid_len, res.sak};
				if (awaited_words.size() == 0) begin
					if (fails < SHOWN_MAX)
						$display("%0t: word with nothing awaited: %p", $time, got);
					fails = fails + 1;
				end else begin
					want = awaited_words.pop_front();
					if (got !== want) begin
						if (fails < SHOWN_MAX)
							$display("%0t: word mismatch\n  expected %p\n  actual   %p",
								$time, want, got);
						fails = fails + 1;
					end
				end
			end
			waiting <= awaited_words.size();
		end
	end

endmodule

FILE: dv/iso14443a_card_select_sequencer_test.sv
`timescale 1ns / 1ps
// top of the card select sequencer testbench: clock, reset, card traffic and verdict
module iso14443a_card_select_sequencer_test;
	import isosel_pkg::*;

	localparam int         RUN_ITEMS   = 220;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         HOLD_CYCLES = 150;
	localparam int         TAIL_CYCLES = 20;
	localparam int         IDLE_PCT    = 38;
	localparam logic [7:0] CASCADE_TAG = 8'h88;

	typedef logic [7:0] byte_q_t[$];

	typedef enum logic [1:0] {
		FAULT_NONE,
		FAULT_SILENT,
		FAULT_RESTART,
		FAULT_MANGLE
	} fault_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned fails;
	int unsigned waiting;
	int          cycles = 0;
	int          sent = 0;
	int          hold_left = 0;
	bit          calm = 1'b0;
	bit          hold_go = 1'b0;
	bit          hold_done = 1'b0;

	isosel_in_if  cmd ();
	isosel_out_if res ();

	iso14443a_card_select_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	iso14443a_card_select_sequencer_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.res     (res),
		.fails   (fails),
		.waiting (waiting)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off so the block backs up
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_done) begin
			res.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			res.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic put_word(input op_t op, input logic [7:0] data, input bit counted = 1'b1);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid   <= 1'b1;
		cmd.op      <= op;
		cmd.rx_data <= data;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		if (counted)
			sent++;
	endtask

	// card reply: the bytes one word each, then end of frame
	task automatic send_reply(input byte_q_t reply);
		foreach (reply[i])
			put_word(OP_BYTE, reply[i]);
		put_word(OP_END, 8'($urandom));
	endtask

	// now and then the card sends more bytes than the reply needs
	task automatic add_tail(ref byte_q_t reply);
		if ($urandom_range(0, 99) < 15)
			repeat ($urandom_range(1, 4))
				reply.push_back(8'($urandom));
	endtask

	function automatic fault_t pick_fault();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return FAULT_SILENT;
		if (r < 6)
			return FAULT_RESTART;
		if (r < 12)
			return FAULT_MANGLE;
		return FAULT_NONE;
	endfunction

	// one selection with random card content, sometimes cut short or broken
	task automatic random_run();
		byte_q_t    reply;
		logic [7:0] bcc;
		logic [7:0] sak;
		fault_t     f;
		bit         two;
		int         lvl;
		int         n;
		two = $urandom_range(0, 1);
		put_word(OP_START, 8'($urandom));
		f = pick_fault();
		if (f == FAULT_SILENT) begin
			put_word(OP_NOANS, 8'($urandom));
			return;
		end
		if (f == FAULT_RESTART)
			return;
		reply.delete();
		if (f == FAULT_MANGLE) begin
			if ($urandom_range(0, 1))
				reply.push_back(8'($urandom));
			send_reply(reply);
			return;
		end
		reply.push_back(8'($urandom));
		reply.push_back(8'($urandom));
		add_tail(reply);
		send_reply(reply);
		for (lvl = 0; lvl < 2; lvl++) begin
			f = pick_fault();
			if (f == FAULT_SILENT) begin
				put_word(OP_NOANS, 8'($urandom));
				return;
			end
			if (f == FAULT_RESTART)
				return;
			reply.delete();
			for (n = 0; n < 4; n++)
				reply.push_back(8'($urandom));
			if (lvl == 0 && two && $urandom_range(0, 4) != 0)
				reply[0] = CASCADE_TAG;
			bcc = reply[0] ^ reply[1] ^ reply[2] ^ reply[3];
			if (f == FAULT_MANGLE && $urandom_range(0, 1)) begin
				n = $urandom_range(0, 4);
				while (reply.size() > n)
					void'(reply.pop_back());
			end else begin
				if (f == FAULT_MANGLE)
					bcc = bcc ^ 8'($urandom_range(1, 255));
				reply.push_back(bcc);
				add_tail(reply);
			end
			send_reply(reply);
			if (f == FAULT_MANGLE)
				return;
			f = pick_fault();
			if (f == FAULT_SILENT) begin
				put_word(OP_NOANS, 8'($urandom));
				return;
			end
			if (f == FAULT_RESTART)
				return;
			reply.delete();
			if (f == FAULT_MANGLE) begin
				send_reply(reply);
				return;
			end
			sak = 8'($urandom);
			if (lvl == 0)
				sak[SAK_CASCADE_BIT] = two;
			reply.push_back(sak);
			add_tail(reply);
			send_reply(reply);
			if (!two)
				return;
		end
	endtask

	initial begin
		cmd.valid   = 1'b0;
		cmd.op      = OP_START;
		cmd.rx_data = 8'd0;
		res.ready   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// words outside a run are dropped
		put_word(OP_BYTE, 8'hFF, 1'b0);
		put_word(OP_END, 8'h00, 1'b0);
		put_word(OP_NOANS, 8'hAA, 1'b0);
		// restart while busy, then an ATQA that is one byte short
		put_word(OP_START, 8'h00);
		put_word(OP_START, 8'hFF);
		put_word(OP_BYTE, 8'h00);
		put_word(OP_END, 8'h55);
		// double-size uid: long ATQA, cascade tag, SAK bit 2 again at level two
		put_word(OP_START, 8'h00);
		send_reply({8'h44, 8'h00, 8'hFF});
		send_reply({CASCADE_TAG, 8'h04, 8'hFF, 8'h00, 8'h73});
		send_reply({8'h04});
		send_reply({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});
		send_reply({8'hFF});

		sent = 0;
		while (sent < RUN_ITEMS) begin
			calm = (sent >= 60 && sent < 110);
			if (sent >= 70)
				hold_go = 1'b1;
			random_run();
			if ($urandom_range(0, 4) == 0)
				put_word(op_t'($urandom_range(1, 3)), 8'($urandom), 1'b0);
		end
		calm = 1'b0;
		cmd.valid <= 1'b0;

		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
